@@ rtl/core/cas_pkg.sv @@
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types and constants for the complex arctangent series block.
// ----------------------------------------------------------------------------
package cas_pkg;

   // Internal values are Q1.31 held in 64-bit signed registers.
   localparam int FRAC_BITS = 31;
   localparam int WORD_W    = 64;
   localparam int MAG_W     = 32;
   localparam int QUOT_W    = 34;
   localparam int OUT_W     = 32;
   localparam int COUNT_W   = 13;
   localparam int EPS_W     = 31;
   localparam logic [EPS_W-1:0] EPS_RESET = 31'd2147484;
   localparam int Q28_SHIFT = FRAC_BITS - 28;

   typedef enum logic [1:0] {
      ST_CONVERGED     = 2'd0,
      ST_NOT_BELOW_ONE = 2'd1,
      ST_LIMIT         = 2'd2
   } rsp_status_type;

   typedef enum logic [3:0] {
      MS_PR_PR   = 4'd0,
      MS_PI_PI   = 4'd1,
      MS_PR_PI   = 4'd2,
      MS_EPS_EPS = 4'd3,
      MS_TR_TR   = 4'd4,
      MS_TI_TI   = 4'd5,
      MS_PR_WR   = 4'd6,
      MS_PI_WI   = 4'd7,
      MS_PR_WI   = 4'd8,
      MS_PI_WR   = 4'd9
   } mul_sel_type;

   typedef enum logic [3:0] {
      WB_NONE   = 4'd0,
      WB_SQ     = 4'd1,
      WB_CHK    = 4'd2,
      WB_T1     = 4'd3,
      WB_WR_SUB = 4'd4,
      WB_WI_DBL = 4'd5,
      WB_EPS2   = 4'd6,
      WB_T2_SUB = 4'd7,
      WB_P_ADD  = 4'd8,
      WB_Q      = 4'd9
   } wb_sel_type;

   typedef struct packed {
      logic           load;
      mul_sel_type    mul_sel;
      wb_sel_type     wb_sel;
      logic           div_start;
      logic           div_imag;
      logic           acc;
      logic           finish;
      rsp_status_type status;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic bad;
      logic conv;
      logic n_last;
   } stat_type;

endpackage

@@ rtl/core/cas_divider.sv @@
// ----------------------------------------------------------------------------
// cas_divider
// Restoring divider, one quotient bit per cycle, rounding half away from zero.
// ----------------------------------------------------------------------------
module cas_divider #(
   parameter int DW = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cas_pkg::MAG_W-1:0]  numer,
   input  logic [DW-1:0]              denom,
   output logic                       done,
   output logic [cas_pkg::QUOT_W-1:0] quot
);

   localparam int QW = cas_pkg::QUOT_W;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0] q_ff, q_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[QW-1]};
      if (start) begin
         // Adding half the divisor first gives the rounded quotient.
         q_in   = QW'(numer) + QW'(denom >> 1);
         rem_in = '0;
         den_in = denom;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(QW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

@@ rtl/core/cas_datapath.sv @@
// ----------------------------------------------------------------------------
// cas_datapath
// Series registers, shared multiplier, divider and accumulators.
// ----------------------------------------------------------------------------
module cas_datapath #(
   parameter int MAX_TERMS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [31:0]                req_z_real,
   input  logic signed [31:0]                req_z_imag,
   input  logic                              csr_write_enable,
   input  logic [cas_pkg::EPS_W-1:0]         csr_write_data,
   input  cas_pkg::cmd_type                  cmd,
   output cas_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   output logic signed [cas_pkg::OUT_W-1:0]  rsp_sum_real,
   output logic signed [cas_pkg::OUT_W-1:0]  rsp_sum_imag,
   output logic [1:0]                        rsp_status,
   output logic [cas_pkg::COUNT_W-1:0]       rsp_terms_added
);

   localparam int W  = cas_pkg::WORD_W;
   localparam int MW = cas_pkg::MAG_W;
   localparam int NW = $clog2(MAX_TERMS + 1);
   localparam int DW = NW + 1;
   localparam int CW = cas_pkg::COUNT_W;
   localparam logic [W:0] HALF = (W+1)'(1) << (cas_pkg::FRAC_BITS - 1);

   function automatic logic [MW-1:0] mag_of(input logic signed [W-1:0] x);
      logic [W-1:0] m;
      m = x[W-1] ? W'(-x) : W'(x);
      return m[MW-1:0];
   endfunction

   function automatic logic signed [W-1:0] to_q28(input logic signed [W-1:0] a);
      logic [W-1:0] m;
      logic [W:0]   r;
      m = a[W-1] ? W'(-a) : W'(a);
      r = ({1'b0, m} + (W+1)'(1 << (cas_pkg::Q28_SHIFT - 1))) >> cas_pkg::Q28_SHIFT;
      if (!a[W-1] && r > (W+1)'(64'h7fffffff)) return W'(64'h7fffffff);
      if (a[W-1] && r > (W+1)'(64'h80000000)) return -W'(64'h80000000);
      return a[W-1] ? -W'(r) : W'(r);
   endfunction

   logic signed [W-1:0] pr_ff, pi_ff, wr_ff, wi_ff, tr_ff, ti_ff;
   logic signed [W-1:0] t1_ff, t2_ff, eps2_ff, accr_ff, acci_ff;
   logic [cas_pkg::EPS_W-1:0] eps_ff;
   logic [W:0]           sq_ff;
   logic [W-1:0]         prod_ff;
   logic                 neg_ff, bad_ff, conv_ff;
   logic [NW-1:0]        n_ff;
   logic                 div_neg_ff, div_imag_ff;
   logic                 valid_ff;
   logic signed [cas_pkg::OUT_W-1:0] sum_r_ff, sum_i_ff;
   logic [1:0]           status_ff;
   logic [CW-1:0]        terms_ff;

   logic signed [W-1:0]  op_a, op_b, rnd;
   logic [W:0]           rsum;
   logic signed [W-1:0]  eps_s;
   logic [MW-1:0]        div_num;
   logic                 div_done;
   logic [cas_pkg::QUOT_W-1:0] quot;
   logic signed [W-1:0]  qs;
   logic [NW+CW-1:0]     n_wide;

   assign eps_s = W'(eps_ff);

   always_comb begin
      case (cmd.mul_sel)
         cas_pkg::MS_PR_PR:   begin op_a = pr_ff; op_b = pr_ff; end
         cas_pkg::MS_PI_PI:   begin op_a = pi_ff; op_b = pi_ff; end
         cas_pkg::MS_PR_PI:   begin op_a = pr_ff; op_b = pi_ff; end
         cas_pkg::MS_EPS_EPS: begin op_a = eps_s; op_b = eps_s; end
         cas_pkg::MS_TR_TR:   begin op_a = tr_ff; op_b = tr_ff; end
         cas_pkg::MS_TI_TI:   begin op_a = ti_ff; op_b = ti_ff; end
         cas_pkg::MS_PR_WR:   begin op_a = pr_ff; op_b = wr_ff; end
         cas_pkg::MS_PI_WI:   begin op_a = pi_ff; op_b = wi_ff; end
         cas_pkg::MS_PR_WI:   begin op_a = pr_ff; op_b = wi_ff; end
         cas_pkg::MS_PI_WR:   begin op_a = pi_ff; op_b = wr_ff; end
         default:             begin op_a = pr_ff; op_b = pr_ff; end
      endcase
   end

   // Rounded product of the previous cycle, half away from zero.
   assign rsum = ({1'b0, prod_ff} + HALF) >> cas_pkg::FRAC_BITS;
   assign rnd  = neg_ff ? -W'(rsum) : W'(rsum);

   assign div_num = cmd.div_imag ? mag_of(pi_ff) : mag_of(pr_ff);
   assign qs      = div_neg_ff ? -W'(quot) : W'(quot);
   assign n_wide  = {{CW{1'b0}}, n_ff};

   cas_divider #(.DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (div_num),
      .denom ({n_ff, 1'b1}),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      prod_ff <= W'(mag_of(op_a)) * W'(mag_of(op_b));
      neg_ff  <= op_a[W-1] ^ op_b[W-1];

      if (cmd.load) begin
         pr_ff <= W'(req_z_real);
         pi_ff <= W'(req_z_imag);
      end

      case (cmd.wb_sel)
         cas_pkg::WB_SQ:     sq_ff   <= {1'b0, prod_ff};
         cas_pkg::WB_CHK:    bad_ff  <= (sq_ff + {1'b0, prod_ff}) >= ((W+1)'(1) << 62);
         cas_pkg::WB_T1:     t1_ff   <= rnd;
         cas_pkg::WB_WR_SUB: wr_ff   <= t1_ff - rnd;
         cas_pkg::WB_WI_DBL: wi_ff   <= rnd + rnd;
         cas_pkg::WB_EPS2:   eps2_ff <= rnd;
         cas_pkg::WB_T2_SUB: t2_ff   <= t1_ff - rnd;
         cas_pkg::WB_P_ADD:  begin
            pr_ff <= t2_ff;
            pi_ff <= t1_ff + rnd;
         end
         cas_pkg::WB_Q:      conv_ff <= (t1_ff + rnd) < eps2_ff;
         default:            ;
      endcase

      if (cmd.div_start) begin
         div_imag_ff <= cmd.div_imag;
         div_neg_ff  <= (cmd.div_imag ? pi_ff[W-1] : pr_ff[W-1]) ^ n_ff[0];
      end
      if (div_done) begin
         if (div_imag_ff) ti_ff <= qs;
         else             tr_ff <= qs;
      end

      if (cmd.finish) begin
         if (cmd.status == cas_pkg::ST_NOT_BELOW_ONE) begin
            sum_r_ff <= '0;
            sum_i_ff <= '0;
            terms_ff <= '0;
         end else begin
            sum_r_ff <= cas_pkg::OUT_W'(to_q28(accr_ff));
            sum_i_ff <= cas_pkg::OUT_W'(to_q28(acci_ff));
            terms_ff <= n_wide[CW-1:0];
         end
         status_ff <= cmd.status;
      end

      if (reset) begin
         valid_ff <= 1'b0;
         n_ff     <= '0;
         accr_ff  <= '0;
         acci_ff  <= '0;
         eps_ff   <= cas_pkg::EPS_RESET;
      end else begin
         valid_ff <= cmd.finish;
         if (csr_write_enable) eps_ff <= csr_write_data;
         if (cmd.load) begin
            n_ff    <= '0;
            accr_ff <= '0;
            acci_ff <= '0;
         end else if (cmd.acc) begin
            n_ff    <= n_ff + 1'b1;
            accr_ff <= accr_ff + tr_ff;
            acci_ff <= acci_ff + ti_ff;
         end
      end
   end

   assign stat.div_done = div_done;
   assign stat.bad      = bad_ff;
   assign stat.conv     = conv_ff;
   assign stat.n_last   = (n_ff == NW'(MAX_TERMS - 1));

   assign rsp_valid       = valid_ff;
   assign rsp_sum_real    = sum_r_ff;
   assign rsp_sum_imag    = sum_i_ff;
   assign rsp_status      = status_ff;
   assign rsp_terms_added = terms_ff;

endmodule

@@ rtl/core/cas_ctrl.sv @@
// ----------------------------------------------------------------------------
// cas_ctrl
// Sequencer that steps the datapath through the series one term at a time.
// ----------------------------------------------------------------------------
module cas_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output cas_pkg::cmd_type   cmd,
   input  cas_pkg::stat_type  stat
);

   typedef enum logic [24:0] {
      S_IDLE  = 25'd1 << 0,
      S_CHK1  = 25'd1 << 1,
      S_CHK2  = 25'd1 << 2,
      S_CHK3  = 25'd1 << 3,
      S_CHK4  = 25'd1 << 4,
      S_W1    = 25'd1 << 5,
      S_W2    = 25'd1 << 6,
      S_W3    = 25'd1 << 7,
      S_W4    = 25'd1 << 8,
      S_W5    = 25'd1 << 9,
      S_D1    = 25'd1 << 10,
      S_D1W   = 25'd1 << 11,
      S_D2    = 25'd1 << 12,
      S_D2W   = 25'd1 << 13,
      S_Q1    = 25'd1 << 14,
      S_Q2    = 25'd1 << 15,
      S_Q3    = 25'd1 << 16,
      S_Q4    = 25'd1 << 17,
      S_ACC   = 25'd1 << 18,
      S_P1    = 25'd1 << 19,
      S_P2    = 25'd1 << 20,
      S_P3    = 25'd1 << 21,
      S_P4    = 25'd1 << 22,
      S_P5    = 25'd1 << 23,
      S_FIN   = 25'd1 << 24
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.mul_sel    = cas_pkg::MS_PR_PR;
      cmd.wb_sel     = cas_pkg::WB_NONE;
      cmd.status     = cas_pkg::ST_CONVERGED;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHK1;
            end
         end
         S_CHK1: state_in = S_CHK2;
         S_CHK2: begin
            cmd.mul_sel = cas_pkg::MS_PI_PI;
            cmd.wb_sel  = cas_pkg::WB_SQ;
            state_in    = S_CHK3;
         end
         S_CHK3: begin
            cmd.wb_sel = cas_pkg::WB_CHK;
            state_in   = S_CHK4;
         end
         S_CHK4: begin
            if (stat.bad) begin
               cmd.finish = 1'b1;
               cmd.status = cas_pkg::ST_NOT_BELOW_ONE;
               state_in   = S_IDLE;
            end else begin
               state_in = S_W1;
            end
         end
         S_W1: state_in = S_W2;
         S_W2: begin
            cmd.mul_sel = cas_pkg::MS_PI_PI;
            cmd.wb_sel  = cas_pkg::WB_T1;
            state_in    = S_W3;
         end
         S_W3: begin
            cmd.mul_sel = cas_pkg::MS_PR_PI;
            cmd.wb_sel  = cas_pkg::WB_WR_SUB;
            state_in    = S_W4;
         end
         S_W4: begin
            cmd.mul_sel = cas_pkg::MS_EPS_EPS;
            cmd.wb_sel  = cas_pkg::WB_WI_DBL;
            state_in    = S_W5;
         end
         S_W5: begin
            cmd.wb_sel = cas_pkg::WB_EPS2;
            state_in   = S_D1;
         end
         S_D1: begin
            cmd.div_start = 1'b1;
            state_in      = S_D1W;
         end
         S_D1W: if (stat.div_done) state_in = S_D2;
         S_D2: begin
            cmd.div_start = 1'b1;
            cmd.div_imag  = 1'b1;
            state_in      = S_D2W;
         end
         S_D2W: if (stat.div_done) state_in = S_Q1;
         S_Q1: begin
            cmd.mul_sel = cas_pkg::MS_TR_TR;
            state_in    = S_Q2;
         end
         S_Q2: begin
            cmd.mul_sel = cas_pkg::MS_TI_TI;
            cmd.wb_sel  = cas_pkg::WB_T1;
            state_in    = S_Q3;
         end
         S_Q3: begin
            cmd.wb_sel = cas_pkg::WB_Q;
            state_in   = S_Q4;
         end
         S_Q4: begin
            if (stat.conv) begin
               cmd.finish = 1'b1;
               cmd.status = cas_pkg::ST_CONVERGED;
               state_in   = S_IDLE;
            end else begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.n_last ? S_FIN : S_P1;
         end
         S_P1: begin
            cmd.mul_sel = cas_pkg::MS_PR_WR;
            state_in    = S_P2;
         end
         S_P2: begin
            cmd.mul_sel = cas_pkg::MS_PI_WI;
            cmd.wb_sel  = cas_pkg::WB_T1;
            state_in    = S_P3;
         end
         S_P3: begin
            cmd.mul_sel = cas_pkg::MS_PR_WI;
            cmd.wb_sel  = cas_pkg::WB_T2_SUB;
            state_in    = S_P4;
         end
         S_P4: begin
            cmd.mul_sel = cas_pkg::MS_PI_WR;
            cmd.wb_sel  = cas_pkg::WB_T1;
            state_in    = S_P5;
         end
         S_P5: begin
            cmd.wb_sel = cas_pkg::WB_P_ADD;
            state_in   = S_D1;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            cmd.status = cas_pkg::ST_LIMIT;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ rtl/core/complex_arctan_series_top.sv @@
// ----------------------------------------------------------------------------
// complex_arctan_series_top
// Complex arctangent of z by its Taylor series, Q1.31 in, Q4.28 out.
// ----------------------------------------------------------------------------
// A word is taken when start is high while busy is low. Busy then stays high
// until the result word appears. The result is shown for exactly one cycle,
// flagged by rsp_valid. The receiver cannot stall it, so it must be captured
// in that cycle. The block first checks whether the squared modulus of the
// input is below one; if it is not, the result word follows without terms.
// Otherwise the block forms z squared and eps squared. For each term it then
// divides the current power of z by (2n+1) for the real and imaginary parts,
// tests the term, adds it to the sum and forms the next power. The shared
// bit-serial divider sets the term time. Each of the two divisions by (2n+1)
// has a start state and a wait state that holds until the divider has made
// all 34 quotient bits. The shared 32 by 32 multiplier and the accumulate
// step take the rest of the term time. The sum ends at the first term whose
// modulus falls below the eps threshold, or after MAX_TERMS terms with a
// limit status. After the test that ends the sum, the result word follows in the next cycle.
//
// The eps threshold register is written through csr_write_enable and
// csr_write_data and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module complex_arctan_series_top #(
   parameter int MAX_TERMS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [31:0]                req_z_real,
   input  logic signed [31:0]                req_z_imag,
   input  logic                              csr_write_enable,
   input  logic [cas_pkg::EPS_W-1:0]         csr_write_data,
   output logic                              rsp_valid,
   output logic signed [cas_pkg::OUT_W-1:0]  rsp_sum_real,
   output logic signed [cas_pkg::OUT_W-1:0]  rsp_sum_imag,
   output logic [1:0]                        rsp_status,
   output logic [cas_pkg::COUNT_W-1:0]       rsp_terms_added
);

   // The controller and datapath talk only through these two buses.
   cas_pkg::cmd_type  cmd;
   cas_pkg::stat_type stat;

   cas_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   cas_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_z_real       (req_z_real),
      .req_z_imag       (req_z_imag),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_sum_real     (rsp_sum_real),
      .rsp_sum_imag     (rsp_sum_imag),
      .rsp_status       (rsp_status),
      .rsp_terms_added  (rsp_terms_added)
   );

endmodule
